### rtl/core/vlhe_pkg.sv
`default_nettype none

package vlhe_pkg;

  // Width of the length fields on the result channel.
  localparam int LEN_W = 6;
  // Width of a parity bit count (at most six parity bits for up to 57 data bits).
  localparam int PAR_W = 3;

  // Fewest parity bits m with 2^m >= k + m + 1.
  function automatic logic [PAR_W-1:0] par_count(input logic [LEN_W-1:0] k);
    logic [PAR_W-1:0] m;
    m = '0;
    for (int i = 0; i < 7; i++) begin
      if ((7'd1 << m) < (7'(k) + 7'(m) + 7'd1)) begin
        m = m + PAR_W'(1);
      end
    end
    return m;
  endfunction

  // Data positions covered by the parity bit at position 2^p (position 1 at bit 0).
  function automatic logic [63:0] cover_mask(input int p);
    logic [63:0] mask;
    mask = '0;
    for (int pos = 1; pos < 64; pos++) begin
      if ((((pos >> p) & 1) == 1) && ((pos & (pos - 1)) != 0)) begin
        mask[pos-1] = 1'b1;
      end
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

### rtl/core/variable_length_hamming_encoder_top.sv
// Channel   Dir  tdata fields (low bit first)                       Transfer
// s_axis    in   data_word[DATA_W]                                  tvalid & tready
// m_axis    out  codeword[CW_W], code_length[6], data_length[6]     tvalid & tready
//
// One word per cycle sustained while m_axis is ready; the length detect register loads
// at the input transfer, then the word passes the queue entry, align and output registers.
// The two-entry queue between length detect and encode lets either side stall.
// Reset clears all valid flags and the queue count; no clearing pass, input ready as soon
// as reset releases.
// A stalled result holds while new words flow into the queue until it fills.
`default_nettype none

module variable_length_hamming_encoder_top #(
  parameter int  DATA_W   = 32,
  localparam int CW_W     = DATA_W + int'(vlhe_pkg::par_count(vlhe_pkg::LEN_W'(DATA_W))),
  localparam int TD_IN_W  = ((DATA_W + 7) / 8) * 8,
  localparam int TD_OUT_W = ((CW_W + 2 * vlhe_pkg::LEN_W + 7) / 8) * 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [TD_IN_W-1:0]  s_axis_tdata_i,   // data_word
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [TD_OUT_W-1:0]      m_axis_tdata_o    // codeword, code_length, data_length
);
  import vlhe_pkg::*;

  localparam int ITEM_W = DATA_W + LEN_W;

  logic              fe_valid;
  logic              fe_ready;
  logic [ITEM_W-1:0] fe_item;
  logic              q_valid;
  logic              q_ready;
  logic [ITEM_W-1:0] q_item;
  logic [CW_W-1:0]   codeword;
  logic [LEN_W-1:0]  code_length;
  logic [LEN_W-1:0]  data_length;

  vlhe_front #(
    .DATA_W (DATA_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_word_i   (s_axis_tdata_i[DATA_W-1:0]),
    .out_valid_o (fe_valid),
    .out_ready_i (fe_ready),
    .out_item_o  (fe_item)
  );

  vlhe_fifo #(
    .WIDTH (ITEM_W)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_item)
  );

  vlhe_back #(
    .DATA_W (DATA_W),
    .CW_W   (CW_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (q_valid),
    .in_ready_o    (q_ready),
    .in_item_i     (q_item),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .codeword_o    (codeword),
    .code_length_o (code_length),
    .data_length_o (data_length)
  );

  assign m_axis_tdata_o = TD_OUT_W'({data_length, code_length, codeword});

  a_dlen_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (data_length != '0) && (data_length <= LEN_W'(DATA_W)))
    else $error("data_length out of range");

  a_parity_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (code_length > data_length + LEN_W'(1))
                        && (code_length <= data_length + LEN_W'(6)))
    else $error("parity bit count out of range");

  a_top_bit_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready && (q_item[ITEM_W-1:DATA_W] != LEN_W'(1)))
      |-> q_item[int'(q_item[ITEM_W-1:DATA_W]) - 1])
    else $error("length does not match top set bit");

endmodule

`default_nettype wire

### rtl/core/vlhe_front.sv
`default_nettype none

module vlhe_front #(
  parameter int DATA_W = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [DATA_W-1:0]                 in_word_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [DATA_W+vlhe_pkg::LEN_W-1:0]      out_item_o
);
  import vlhe_pkg::*;

  logic              vld_q;
  logic [DATA_W-1:0] word_q;
  logic [LEN_W-1:0]  k_q;
  logic [LEN_W-1:0]  k_d;
  logic              load;

  // Significant length: index of the top set bit plus one, zero counts as one bit.
  always_comb begin
    k_d = LEN_W'(1);
    for (int i = 0; i < DATA_W; i++) begin
      if (in_word_i[i]) begin
        k_d = LEN_W'(i + 1);
      end
    end
  end

  assign in_ready_o = !vld_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_word_i;
      k_q    <= k_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_item_o  = {k_q, word_q};

endmodule

`default_nettype wire

### rtl/core/vlhe_fifo.sv
`default_nettype none

module vlhe_fifo #(
  parameter int WIDTH = 38
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  logic [1:0]       cnt_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != 2'(DEPTH));
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/vlhe_back.sv
`default_nettype none

module vlhe_back #(
  parameter int DATA_W = 32,
  parameter int CW_W   = 38
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [DATA_W+vlhe_pkg::LEN_W-1:0] in_item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [CW_W-1:0]                        codeword_o,
  output logic [vlhe_pkg::LEN_W-1:0]             code_length_o,
  output logic [vlhe_pkg::LEN_W-1:0]             data_length_o
);
  import vlhe_pkg::*;

  logic [DATA_W-1:0] in_word;
  logic [LEN_W-1:0]  in_k;
  logic [LEN_W-1:0]  shamt;

  // Stage 1: left-align the significant bits, count parity bits.
  logic              vld1_q;
  logic [DATA_W-1:0] aligned_q;
  logic [LEN_W-1:0]  k1_q;
  logic [PAR_W-1:0]  m1_q;

  // Stage 2: output register.
  logic              vld2_q;
  logic [CW_W-1:0]   cw_q;
  logic [LEN_W-1:0]  total_q;
  logic [LEN_W-1:0]  k2_q;

  logic              en1;
  logic              en2;
  logic [CW_W-1:0]   dvec;
  logic [CW_W-1:0]   pvec;

  assign in_word = in_item_i[DATA_W-1:0];
  assign in_k    = in_item_i[DATA_W+LEN_W-1:DATA_W];
  assign shamt   = LEN_W'(DATA_W) - in_k;

  assign en2        = !vld2_q || out_ready_i;
  assign en1        = !vld1_q || en2;
  assign in_ready_o = en1;

  // Scatter data MSB first over the non power-of-two positions; parity at the rest.
  for (genvar pos = 1; pos <= CW_W; pos++) begin : g_pos
    if ((pos & (pos - 1)) == 0) begin : g_par
      localparam logic [CW_W-1:0] MASK = CW_W'(cover_mask($clog2(pos)));
      assign dvec[pos-1] = 1'b0;
      assign pvec[pos-1] = ^(dvec & MASK);
    end else begin : g_dat
      localparam int DI = pos - $clog2(pos + 1) - 1;
      assign dvec[pos-1] = aligned_q[DATA_W-1-DI];
      assign pvec[pos-1] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      if (en1) begin
        vld1_q <= in_valid_i;
      end
      if (en2) begin
        vld2_q <= vld1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      aligned_q <= in_word << shamt;
      k1_q      <= in_k;
      m1_q      <= par_count(in_k);
    end
    if (en2 && vld1_q) begin
      cw_q    <= dvec | pvec;
      total_q <= k1_q + LEN_W'(m1_q);
      k2_q    <= k1_q;
    end
  end

  assign out_valid_o   = vld2_q;
  assign codeword_o    = cw_q;
  assign code_length_o = total_q;
  assign data_length_o = k2_q;

endmodule

`default_nettype wire
